// ----- src/biu_pkg.sv -----
// Package with the item types, register indexes and defaults of the bilinear upscaler.
package biu_pkg;

  localparam int IMG_DEPTH_DEF = 65536;
  localparam int FRAC_BITS_DEF = 12;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam logic [8:0]  IN_WIDTH_RST   = 9'd256;
  localparam logic [8:0]  IN_HEIGHT_RST  = 9'd256;
  localparam logic [12:0] OUT_WIDTH_RST  = 13'd512;
  localparam logic [12:0] OUT_HEIGHT_RST = 13'd2048;

  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IN_WIDTH   = 3'd0,
    REG_IN_HEIGHT  = 3'd1,
    REG_OUT_WIDTH  = 3'd2,
    REG_OUT_HEIGHT = 3'd3
  } cfg_reg_t;

  typedef struct packed {
    logic        req_type;
    logic [15:0] pix_addr;
    logic [7:0]  src_red;
    logic [7:0]  src_green;
    logic [7:0]  src_blue;
    logic [11:0] out_row;
    logic [11:0] out_col;
  } item_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
    logic       range_error;
  } result_t;

endpackage

// ----- src/bilinear_image_upscaler_core.sv -----
// Top level of the bilinear upscaler: coordinate dividers, address stages, image store, blend.
//
// An item is taken on cmd at every rising edge where start is high and busy is low.
// busy stays low, so one item can be accepted in every cycle.
// A write item (req_type 0) stores one RGB source pixel; a request item (req_type 1)
// returns one interpolated pixel on result, marked by done for exactly one cycle.
// Request results leave in the order of acceptance at up to one per cycle.
// The two coordinate dividers resolve one quotient bit per stage over 9 + FRAC_BITS
// stages, and are followed by address, memory read and blend stages.
// Each of the four neighbour reads has its own copy of the image store, and every
// write item updates all four copies in the same pipeline slot where reads happen,
// so writes and requests act in their order of acceptance.
// Configuration registers are written through cfg_we, cfg_index and cfg_data, which the user
// must do only while no item is in flight; the block itself does not enforce this. Writes to
// an unknown index are dropped. Synchronous reset empties the pipeline and restores the default
// image sizes; the image store is not cleared and holds undefined data until written.
// The receiver cannot stall, so nothing ever holds the pipeline.
module bilinear_image_upscaler_core #(
  parameter int IMG_DEPTH = biu_pkg::IMG_DEPTH_DEF,
  parameter int FRAC_BITS = biu_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  biu_pkg::item_t                  cmd,
  input  logic                            cfg_we,
  input  logic [biu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [biu_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                            done,
  output biu_pkg::result_t                result
);

  localparam int F   = FRAC_BITS;
  localparam int Q   = 9 + F;
  localparam int WW  = 2 * F + 1;
  localparam int PW  = WW + 8;
  localparam int SW  = PW + 2;
  localparam int AW  = $clog2(IMG_DEPTH);
  localparam int ADW = (AW > 19) ? AW : 19;
  localparam logic [F:0] S_ONE = (F + 1)'(1) << F;

  typedef struct packed {
    logic        is_req;
    logic        rerr;
    logic [15:0] waddr;
    logic [23:0] wdata;
  } meta_t;

  logic [8:0]  src_cols;
  logic [8:0]  src_rows;
  logic [12:0] dst_cols;
  logic [12:0] dst_rows;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_cols <= biu_pkg::IN_WIDTH_RST;
      src_rows <= biu_pkg::IN_HEIGHT_RST;
      dst_cols <= biu_pkg::OUT_WIDTH_RST;
      dst_rows <= biu_pkg::OUT_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        biu_pkg::REG_IN_WIDTH:   src_cols <= cfg_data[8:0];
        biu_pkg::REG_IN_HEIGHT:  src_rows <= cfg_data[8:0];
        biu_pkg::REG_OUT_WIDTH:  dst_cols <= cfg_data;
        biu_pkg::REG_OUT_HEIGHT: dst_rows <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic [8:0] iw;
  logic [8:0] span_w;
  logic [8:0] span_h;
  logic       accept;

  assign iw     = (src_cols == 9'd0) ? 9'd1 : src_cols;
  assign span_w = iw - 9'd1;
  assign span_h = (src_rows == 9'd0) ? 9'd0 : src_rows - 9'd1;
  assign accept = start && !busy;

  // Input stage: span products and range check.
  logic        p_valid;
  meta_t       p_meta;
  logic [20:0] p_prod_r;
  logic [20:0] p_prod_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    p_meta.is_req <= cmd.req_type;
    p_meta.rerr   <= ({1'b0, cmd.out_row} >= dst_rows) || ({1'b0, cmd.out_col} >= dst_cols);
    p_meta.waddr  <= cmd.pix_addr;
    p_meta.wdata  <= {cmd.src_red, cmd.src_green, cmd.src_blue};
    p_prod_r      <= 21'(cmd.out_row * span_h);
    p_prod_c      <= 21'(cmd.out_col * span_w);
  end

  // Restoring dividers, one quotient bit per stage.
  logic          d_valid [Q];
  meta_t         d_meta  [Q];
  logic [12:0]   rem_r   [Q];
  logic [12:0]   rem_c   [Q];
  logic [Q-1:0]  num_r   [Q];
  logic [Q-1:0]  num_c   [Q];
  logic [Q-1:0]  quo_r   [Q];
  logic [Q-1:0]  quo_c   [Q];

  for (genvar k = 0; k < Q; k++) begin : g_div
    logic         pv;
    meta_t        pm;
    logic [12:0]  pr;
    logic [12:0]  pc;
    logic [Q-1:0] pnr;
    logic [Q-1:0] pnc;
    logic [Q-1:0] pqr;
    logic [Q-1:0] pqc;
    logic [13:0]  tr;
    logic [13:0]  tc;
    logic         ger;
    logic         gec;

    if (k == 0) begin : g_first
      assign pv  = p_valid;
      assign pm  = p_meta;
      assign pr  = {1'b0, p_prod_r[20:9]};
      assign pc  = {1'b0, p_prod_c[20:9]};
      assign pnr = {p_prod_r[8:0], {F{1'b0}}};
      assign pnc = {p_prod_c[8:0], {F{1'b0}}};
      assign pqr = '0;
      assign pqc = '0;
    end else begin : g_rest
      assign pv  = d_valid[k-1];
      assign pm  = d_meta[k-1];
      assign pr  = rem_r[k-1];
      assign pc  = rem_c[k-1];
      assign pnr = num_r[k-1];
      assign pnc = num_c[k-1];
      assign pqr = quo_r[k-1];
      assign pqc = quo_c[k-1];
    end

    assign tr  = {pr, pnr[Q-1]};
    assign tc  = {pc, pnc[Q-1]};
    assign ger = tr >= {1'b0, dst_rows};
    assign gec = tc >= {1'b0, dst_cols};

    always_ff @(posedge clk) begin
      if (rst) begin
        d_valid[k] <= 1'b0;
      end else begin
        d_valid[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      d_meta[k] <= pm;
      rem_r[k]  <= ger ? 13'(tr - {1'b0, dst_rows}) : tr[12:0];
      rem_c[k]  <= gec ? 13'(tc - {1'b0, dst_cols}) : tc[12:0];
      num_r[k]  <= {pnr[Q-2:0], 1'b0};
      num_c[k]  <= {pnc[Q-2:0], 1'b0};
      quo_r[k]  <= {pqr[Q-2:0], ger};
      quo_c[k]  <= {pqc[Q-2:0], gec};
    end
  end

  // Floor, ceiling and weights.
  logic         m1_valid;
  meta_t        m1_meta;
  logic [8:0]   m1_lo_r;
  logic [8:0]   m1_hi_r;
  logic [8:0]   m1_lo_c;
  logic [8:0]   m1_hi_c;
  logic [F:0]   m1_a;
  logic [F:0]   m1_b;
  logic [Q-1:0] qr;
  logic [Q-1:0] qc;
  logic [F-1:0] fy;
  logic [F-1:0] fx;

  assign qr = quo_r[Q-1];
  assign qc = quo_c[Q-1];
  assign fy = qr[F-1:0];
  assign fx = qc[F-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
    end else begin
      m1_valid <= d_valid[Q-1];
    end
  end

  always_ff @(posedge clk) begin
    m1_meta <= d_meta[Q-1];
    m1_lo_r <= qr[Q-1:F];
    m1_hi_r <= qr[Q-1:F] + {8'd0, fy != '0};
    m1_lo_c <= qc[Q-1:F];
    m1_hi_c <= qc[Q-1:F] + {8'd0, fx != '0};
    m1_a    <= (fy == '0) ? '0 : S_ONE - {1'b0, fy};
    m1_b    <= (fx == '0) ? '0 : S_ONE - {1'b0, fx};
  end

  // Row offsets and weight products.
  logic          m2_valid;
  meta_t         m2_meta;
  logic [17:0]   m2_off_f;
  logic [17:0]   m2_off_c;
  logic [8:0]    m2_lo_c;
  logic [8:0]    m2_hi_c;
  logic [WW-1:0] m2_w [4];
  logic [F:0]    na;
  logic [F:0]    nb;

  assign na = S_ONE - m1_a;
  assign nb = S_ONE - m1_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_valid <= 1'b0;
    end else begin
      m2_valid <= m1_valid;
    end
  end

  always_ff @(posedge clk) begin
    m2_meta  <= m1_meta;
    m2_off_f <= 18'(m1_lo_r * iw);
    m2_off_c <= 18'(m1_hi_r * iw);
    m2_lo_c  <= m1_lo_c;
    m2_hi_c  <= m1_hi_c;
    m2_w[0]  <= WW'(m1_a * m1_b);
    m2_w[1]  <= WW'(na * m1_b);
    m2_w[2]  <= WW'(m1_a * nb);
    m2_w[3]  <= WW'(na * nb);
  end

  // Neighbour addresses, in the order (fr,fc), (cr,fc), (fr,cc), (cr,cc).
  logic          m3_valid;
  meta_t         m3_meta;
  logic [ADW-1:0] m3_addr [4];
  logic [3:0]    m3_oob;
  logic [WW-1:0] m3_w [4];
  logic [ADW-1:0] na_addr [4];

  assign na_addr[0] = ADW'(m2_off_f) + ADW'(m2_lo_c);
  assign na_addr[1] = ADW'(m2_off_c) + ADW'(m2_lo_c);
  assign na_addr[2] = ADW'(m2_off_f) + ADW'(m2_hi_c);
  assign na_addr[3] = ADW'(m2_off_c) + ADW'(m2_hi_c);

  always_ff @(posedge clk) begin
    if (rst) begin
      m3_valid <= 1'b0;
    end else begin
      m3_valid <= m2_valid;
    end
  end

  always_ff @(posedge clk) begin
    m3_meta <= m2_meta;
    for (int i = 0; i < 4; i++) begin
      m3_addr[i] <= na_addr[i];
      m3_oob[i]  <= {1'b0, na_addr[i]} >= (ADW + 1)'(IMG_DEPTH);
      m3_w[i]    <= m2_w[i];
    end
  end

  // Image store copies, one per neighbour.
  logic           wr_en;
  logic [ADW-1:0] wr_ext;
  logic [23:0]    rd_data [4];

  assign wr_ext = ADW'(m3_meta.waddr);
  assign wr_en  = m3_valid && !m3_meta.is_req && ({1'b0, wr_ext} < (ADW + 1)'(IMG_DEPTH));

  for (genvar i = 0; i < 4; i++) begin : g_store
    logic [ADW-1:0] ra;
    assign ra = m3_addr[i];
    biu_ram #(
      .WIDTH(24),
      .DEPTH(IMG_DEPTH)
    ) u_ram (
      .clk  (clk),
      .we   (wr_en),
      .waddr(wr_ext[AW-1:0]),
      .wdata(m3_meta.wdata),
      .raddr(ra[AW-1:0]),
      .rdata(rd_data[i])
    );
  end

  // Memory data stage.
  logic          m4_valid;
  meta_t         m4_meta;
  logic [3:0]    m4_oob;
  logic [WW-1:0] m4_w [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      m4_valid <= 1'b0;
    end else begin
      m4_valid <= m3_valid;
    end
  end

  always_ff @(posedge clk) begin
    m4_meta <= m3_meta;
    m4_oob  <= m3_oob;
    for (int i = 0; i < 4; i++) begin
      m4_w[i] <= m3_w[i];
    end
  end

  // Channel products.
  logic          m5_valid;
  meta_t         m5_meta;
  logic [PW-1:0] m5_prod [4][3];
  logic [23:0]   pix [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      pix[i] = m4_oob[i] ? 24'd0 : rd_data[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m5_valid <= 1'b0;
    end else begin
      m5_valid <= m4_valid;
    end
  end

  always_ff @(posedge clk) begin
    m5_meta <= m4_meta;
    for (int i = 0; i < 4; i++) begin
      m5_prod[i][0] <= PW'(m4_w[i] * pix[i][23:16]);
      m5_prod[i][1] <= PW'(m4_w[i] * pix[i][15:8]);
      m5_prod[i][2] <= PW'(m4_w[i] * pix[i][7:0]);
    end
  end

  // Sum and output register.
  logic [SW-1:0] chan_sum [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      chan_sum[c] = SW'(m5_prod[0][c]) + SW'(m5_prod[1][c])
                  + SW'(m5_prod[2][c]) + SW'(m5_prod[3][c]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= m5_valid && m5_meta.is_req;
    end
  end

  always_ff @(posedge clk) begin
    result.alpha_out   <= biu_pkg::ALPHA_OPAQUE;
    result.range_error <= m5_meta.rerr;
    result.red_out     <= m5_meta.rerr ? 8'd0 : chan_sum[0][2*F+7:2*F];
    result.green_out   <= m5_meta.rerr ? 8'd0 : chan_sum[1][2*F+7:2*F];
    result.blue_out    <= m5_meta.rerr ? 8'd0 : chan_sum[2][2*F+7:2*F];
  end

endmodule

// ----- src/biu_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module biu_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sim/biu_checker.sv -----
// Checker for the bilinear upscaler: mirrors its image store and sizes and compares each result.
module biu_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  biu_pkg::item_t    cmd,
  input  logic              cfg_we,
  input  logic [biu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [biu_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic              done,
  input  biu_pkg::result_t  result,
  output int                pending,
  output int                failures
);

  localparam int FB = biu_pkg::FRAC_BITS_DEF;
  localparam longint unsigned SCALE = 64'd1 << FB;

  logic [23:0]      pixel_mem [biu_pkg::IMG_DEPTH_DEF];
  logic [8:0]       src_w, src_h;
  logic [12:0]      dst_w, dst_h;
  biu_pkg::result_t pixel_queue[$];

  function automatic void map_axis(input longint unsigned pos, input longint unsigned in_sz,
                                   input longint unsigned out_sz, output longint unsigned lo,
                                   output longint unsigned hi, output longint unsigned wt);
    longint unsigned span, fixed, frac;
    span  = (in_sz == 0) ? 0 : in_sz - 1;
    fixed = ((pos * span) << FB) / out_sz;
    frac  = fixed & (SCALE - 1);
    lo    = fixed >> FB;
    hi    = lo + ((frac != 0) ? 1 : 0);
    wt    = (frac == 0) ? 0 : SCALE - frac;
  endfunction

  function automatic logic [23:0] fetch(input longint unsigned addr);
    return (addr >= biu_pkg::IMG_DEPTH_DEF) ? 24'd0 : pixel_mem[addr];
  endfunction

  function automatic logic [7:0] mix(input logic [7:0] c00, input logic [7:0] c10,
                                     input logic [7:0] c01, input logic [7:0] c11,
                                     input longint unsigned a, input longint unsigned b);
    longint unsigned sum;
    sum = a * b * c00 + (SCALE - a) * b * c10 + a * (SCALE - b) * c01
        + (SCALE - a) * (SCALE - b) * c11;
    return 8'((sum >> (2 * FB)) & 64'hFF);
  endfunction

  function automatic biu_pkg::result_t interpolate(input biu_pkg::item_t it);
    biu_pkg::result_t r;
    longint unsigned iw, fr, cr, fc, cc, a, b;
    logic [23:0] p00, p10, p01, p11;
    r = '0;
    r.alpha_out = biu_pkg::ALPHA_OPAQUE;
    if (it.out_row >= dst_h || it.out_col >= dst_w) begin
      r.range_error = 1'b1;
      return r;
    end
    iw = (src_w == 0) ? 1 : src_w;
    map_axis(it.out_row, src_h, dst_h, fr, cr, a);
    map_axis(it.out_col, iw, dst_w, fc, cc, b);
    p00 = fetch(fr * iw + fc);
    p10 = fetch(cr * iw + fc);
    p01 = fetch(fr * iw + cc);
    p11 = fetch(cr * iw + cc);
    r.red_out   = mix(p00[23:16], p10[23:16], p01[23:16], p11[23:16], a, b);
    r.green_out = mix(p00[15:8], p10[15:8], p01[15:8], p11[15:8], a, b);
    r.blue_out  = mix(p00[7:0], p10[7:0], p01[7:0], p11[7:0], a, b);
    return r;
  endfunction

  initial begin
    failures = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    biu_pkg::result_t want;
    if (rst) begin
      src_w = biu_pkg::IN_WIDTH_RST;
      src_h = biu_pkg::IN_HEIGHT_RST;
      dst_w = biu_pkg::OUT_WIDTH_RST;
      dst_h = biu_pkg::OUT_HEIGHT_RST;
      pixel_queue.delete();
    end else begin
      if (done) begin
        if (pixel_queue.size() == 0) begin
          $error("result with no request waiting");
          failures++;
        end else begin
          want = pixel_queue.pop_front();
          if (result.red_out !== want.red_out) begin
            $error("red_out expected %0d actual %0d", want.red_out, result.red_out);
            failures++;
          end
          if (result.green_out !== want.green_out) begin
            $error("green_out expected %0d actual %0d", want.green_out, result.green_out);
            failures++;
          end
          if (result.blue_out !== want.blue_out) begin
            $error("blue_out expected %0d actual %0d", want.blue_out, result.blue_out);
            failures++;
          end
          if (result.alpha_out !== want.alpha_out) begin
            $error("alpha_out expected %0d actual %0d", want.alpha_out, result.alpha_out);
            failures++;
          end
          if (result.range_error !== want.range_error) begin
            $error("range_error expected %0d actual %0d", want.range_error,
                   result.range_error);
            failures++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          biu_pkg::REG_IN_WIDTH:   src_w = cfg_data[8:0];
          biu_pkg::REG_IN_HEIGHT:  src_h = cfg_data[8:0];
          biu_pkg::REG_OUT_WIDTH:  dst_w = cfg_data;
          biu_pkg::REG_OUT_HEIGHT: dst_h = cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (cmd.req_type == 1'b0) begin
          pixel_mem[cmd.pix_addr] = {cmd.src_red, cmd.src_green, cmd.src_blue};
        end else begin
          pixel_queue.push_back(interpolate(cmd));
        end
      end
    end
    pending = pixel_queue.size();
  end
endmodule

// ----- sim/testbench.sv -----
// Testbench top for the bilinear upscaler: clock, reset, stimulus phases and the verdict.
module testbench;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  biu_pkg::item_t cmd = '0;
  logic cfg_we = 1'b0;
  logic [biu_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [biu_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic done;
  biu_pkg::result_t result;
  int pending, failures;

  bit written [biu_pkg::IMG_DEPTH_DEF];
  int cur_iw, cur_ih, cur_ow, cur_oh;
  int sent = 0;
  int idle_pct = 35;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  bilinear_image_upscaler_core u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .result(result)
  );

  biu_checker u_chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .result(result), .pending(pending), .failures(failures)
  );

  task automatic issue(input biu_pkg::item_t it);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    cmd <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
    idle_pct = (sent < 350) ? 35 : (sent < 700) ? 72 : 0;
  endtask

  task automatic write_pixel(input int addr, input int rgb);
    biu_pkg::item_t it;
    it = biu_pkg::item_t'($urandom);
    it.req_type = 1'b0;
    it.pix_addr = addr[15:0];
    {it.src_red, it.src_green, it.src_blue} = rgb[23:0];
    written[addr[15:0]] = 1'b1;
    issue(it);
  endtask

  function automatic int rand_rgb();
    case ($urandom_range(5))
      0: return 24'h000000;
      1: return 24'hFFFFFF;
      default: return $urandom & 24'hFFFFFF;
    endcase
  endfunction

  // Source rows or columns touched by one output coordinate.
  function automatic void span_of(input int pos, input int in_sz, input int out_sz,
                                  output int lo, output int hi);
    longint unsigned fixed;
    fixed = ((longint'(pos) * ((in_sz == 0) ? 0 : in_sz - 1)) << biu_pkg::FRAC_BITS_DEF)
          / out_sz;
    lo = int'(fixed >> biu_pkg::FRAC_BITS_DEF);
    hi = lo + ((fixed[biu_pkg::FRAC_BITS_DEF-1:0] != 0) ? 1 : 0);
  endfunction

  // For an in-range request, fills any unwritten neighbour inside the image store first, then sends the request.
  task automatic request(input int row, input int col);
    biu_pkg::item_t it;
    int iw, r0, r1, c0, c1, a;
    int addrs[4];
    row = row & 'hFFF;
    col = col & 'hFFF;
    if (row < cur_oh && col < cur_ow) begin
      iw = (cur_iw == 0) ? 1 : cur_iw;
      span_of(row, cur_ih, cur_oh, r0, r1);
      span_of(col, iw, cur_ow, c0, c1);
      addrs = '{r0 * iw + c0, r1 * iw + c0, r0 * iw + c1, r1 * iw + c1};
      foreach (addrs[k]) begin
        a = addrs[k];
        if (a < biu_pkg::IMG_DEPTH_DEF && !written[a]) write_pixel(a, rand_rgb());
      end
    end
    it = biu_pkg::item_t'({$urandom, $urandom});
    it.req_type = 1'b1;
    it.out_row = row[11:0];
    it.out_col = col[11:0];
    issue(it);
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    wait (pending == 0);
    repeat (40) @(negedge clk);
  endtask

  task automatic configure(input int iw, input int ih, input int ow, input int oh);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= biu_pkg::REG_IN_WIDTH;   cfg_data <= 13'(iw);
    @(negedge clk);
    cfg_index <= biu_pkg::REG_IN_HEIGHT;  cfg_data <= 13'(ih);
    @(negedge clk);
    cfg_index <= biu_pkg::REG_OUT_WIDTH;  cfg_data <= 13'(ow);
    @(negedge clk);
    cfg_index <= biu_pkg::REG_OUT_HEIGHT; cfg_data <= 13'(oh);
    @(negedge clk);
    cfg_index <= 3'd6;                    cfg_data <= 13'h1FFF;
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_iw = iw; cur_ih = ih; cur_ow = ow; cur_oh = oh;
  endtask

  task automatic run_phase(input int count);
    int row, col, iw, stop;
    request(0, 0);
    request(cur_oh - 1, cur_ow - 1);
    request(0, cur_ow - 1);
    request(cur_oh - 1, 0);
    request(cur_oh, 0);
    request(0, cur_ow);
    request(4095, 4095);
    iw = (cur_iw == 0) ? 1 : cur_iw;
    stop = sent + count;
    while (sent < stop) begin
      case ($urandom_range(19))
        0, 1, 2, 3: write_pixel($urandom_range(65535), rand_rgb());
        4: write_pixel($urandom_range(iw * ((cur_ih == 0) ? 1 : cur_ih) - 1), rand_rgb());
        5: request($urandom_range(4095), $urandom_range(4095));
        default: begin
          row = (cur_oh == 0) ? 0 : $urandom_range(cur_oh - 1);
          col = (cur_ow == 0) ? 0 : $urandom_range(cur_ow - 1);
          request(row, col);
        end
      endcase
    end
  endtask

  initial begin
    cur_iw = biu_pkg::IN_WIDTH_RST; cur_ih = biu_pkg::IN_HEIGHT_RST;
    cur_ow = biu_pkg::OUT_WIDTH_RST; cur_oh = biu_pkg::OUT_HEIGHT_RST;
    repeat (3) @(negedge clk);
    rst = 1'b0;
    write_pixel(0, 24'h000000);
    write_pixel(65535, 24'hFFFFFF);
    run_phase(150);
    configure(1, 1, 1, 1);
    run_phase(110);
    configure(256, 256, 4096, 4096);
    run_phase(150);
    configure(0, 0, 0, 0);
    run_phase(40);
    configure(3, 5, 7, 11);
    run_phase(140);
    configure(16, 16, 37, 50);
    run_phase(140);
    configure(200, 150, 8191, 13);
    run_phase(150);
    drain();
    if (failures == 0) begin
      $display("bilinear_image_upscaler_core regression: pass");
    end else begin
      $display("bilinear_image_upscaler_core regression: fail");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("bilinear_image_upscaler_core regression: fail");
    $finish;
  end
endmodule
